// File: src/dfnms_pkg.sv
// Shared types and constants for the detection filter with box suppression.
`default_nettype none
package dfnms_pkg;

    // Most results one frame can give, and the widths that follow from it
    localparam int OUT_CAP = 64;
    localparam int KW      = 7;
    localparam int KIW     = 6;

    // Configuration register indexes
    localparam logic [2:0] REG_CONF_THR  = 3'd0;
    localparam logic [2:0] REG_IOU_THR   = 3'd1;
    localparam logic [2:0] REG_KEEP_LIM  = 3'd2;
    localparam logic [2:0] REG_BOX_FMT   = 3'd3;
    localparam logic [2:0] REG_FALLBACK  = 3'd4;
    localparam logic [2:0] REG_INV_SCALE = 3'd5;
    localparam logic [2:0] REG_PAD       = 3'd6;
    localparam logic [2:0] REG_EXTENT    = 3'd7;

    // Box format codes
    localparam logic [1:0] FMT_CS_NOCLS = 2'd0;
    localparam logic [1:0] FMT_CORNERS  = 2'd1;
    localparam logic [1:0] FMT_CS_CLS   = 2'd2;

    typedef struct packed {
        logic [15:0] conf_thr;
        logic [15:0] iou_thr;
        logic [6:0]  keep_limit;
        logic [1:0]  box_format;
        logic [7:0]  fallback_class;
        logic [15:0] inv_scale;
        logic [31:0] pad_offset;
        logic [31:0] image_extent;
    } cfg_t;

    // Mapped candidate handed from the front end to the store
    typedef struct packed {
        logic        valid;
        logic        keep;
        logic        last;
        logic [63:0] box;   // bottom, right, top, left from msb down
        logic [23:0] sc;    // class in 23:16, score in 15:0
    } cand_t;

endpackage
`default_nettype wire

// File: src/dfnms_front.sv
// Candidate front end: score filter, corner conversion, letterbox undo, clamp.
`default_nettype none
module dfnms_front
    import dfnms_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire logic [15:0] coord_a,
    input  wire logic [15:0] coord_b,
    input  wire logic [15:0] coord_c,
    input  wire logic [15:0] coord_d,
    input  wire logic [15:0] score,
    input  wire logic [7:0]  class_in,
    input  wire logic        last,
    input  wire cfg_t        cfg,
    output cand_t            cand
);

    // Round a Q.17 product to Q12.4 and cap it
    function automatic logic [15:0] map_edge(input logic signed [35:0] p,
                                             input logic [15:0] lim);
        logic [35:0] sum;
        logic [22:0] r;
        sum = {1'b0, p[34:0]} + 36'd4096;
        r   = sum[35:13];
        if (p[35] || p == 36'sd0) begin
            return 16'd0;
        end
        if (r > {7'd0, lim}) begin
            return lim;
        end
        return r[15:0];
    endfunction

    logic signed [17:0] ax2, bx2, cx2, dx2, ce, de;
    logic signed [17:0] n0, n1, n2, n3;
    logic signed [18:0] d0, d1, d2, d3;
    logic signed [18:0] padx2, pady2;
    logic [15:0] limx, limy;

    logic               v1_reg, v2_reg, v3_reg;
    logic               ok1_reg, ok2_reg, ok3_reg;
    logic               l1_reg, l2_reg, l3_reg;
    logic [23:0]        sc1_reg, sc2_reg, sc3_reg;
    logic signed [18:0] d0_reg, d1_reg, d2_reg, d3_reg;
    logic signed [35:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [15:0]        e0_reg, e1_reg, e2_reg, e3_reg;
    logic signed [16:0] inv_s;

    // Edge numerators in half units, less twice the pad
    always_comb begin
        ax2 = {coord_a[15], coord_a, 1'b0};
        bx2 = {coord_b[15], coord_b, 1'b0};
        cx2 = {coord_c[15], coord_c, 1'b0};
        dx2 = {coord_d[15], coord_d, 1'b0};
        ce  = {{2{coord_c[15]}}, coord_c};
        de  = {{2{coord_d[15]}}, coord_d};
        if (cfg.box_format == FMT_CORNERS) begin
            n0 = ax2; n1 = bx2; n2 = cx2; n3 = dx2;
        end else begin
            n0 = ax2 - ce; n1 = bx2 - de; n2 = ax2 + ce; n3 = bx2 + de;
        end
        padx2 = $signed({2'b00, cfg.pad_offset[15:0], 1'b0});
        pady2 = $signed({2'b00, cfg.pad_offset[31:16], 1'b0});
        d0 = {n0[17], n0} - padx2;
        d1 = {n1[17], n1} - pady2;
        d2 = {n2[17], n2} - padx2;
        d3 = {n3[17], n3} - pady2;
        limx = (cfg.image_extent[15:12] != 4'd0) ? 16'hFFFF
                                                 : {cfg.image_extent[11:0], 4'd0};
        limy = (cfg.image_extent[31:28] != 4'd0) ? 16'hFFFF
                                                 : {cfg.image_extent[27:16], 4'd0};
        inv_s = $signed({1'b0, cfg.inv_scale});
    end

    // Valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload: numerators, then products, then mapped edges
    always_ff @(posedge aclk) begin
        ok1_reg <= (score >= cfg.conf_thr);
        l1_reg  <= last;
        sc1_reg <= {(cfg.box_format == FMT_CS_NOCLS) ? cfg.fallback_class : class_in,
                    score};
        d0_reg  <= d0;
        d1_reg  <= d1;
        d2_reg  <= d2;
        d3_reg  <= d3;

        ok2_reg <= ok1_reg;
        l2_reg  <= l1_reg;
        sc2_reg <= sc1_reg;
        p0_reg  <= d0_reg * inv_s;
        p1_reg  <= d1_reg * inv_s;
        p2_reg  <= d2_reg * inv_s;
        p3_reg  <= d3_reg * inv_s;

        ok3_reg <= ok2_reg;
        l3_reg  <= l2_reg;
        sc3_reg <= sc2_reg;
        e0_reg  <= map_edge(p0_reg, limx);
        e1_reg  <= map_edge(p1_reg, limy);
        e2_reg  <= map_edge(p2_reg, limx);
        e3_reg  <= map_edge(p3_reg, limy);
    end

    // Empty boxes are not kept
    always_comb begin
        cand.valid = v3_reg;
        cand.keep  = ok3_reg && (e2_reg > e0_reg) && (e3_reg > e1_reg);
        cand.last  = l3_reg;
        cand.box   = {e3_reg, e2_reg, e1_reg, e0_reg};
        cand.sc    = sc3_reg;
    end

endmodule
`default_nettype wire

// File: src/dfnms_core.sv
// Candidate store, score ordering, greedy suppression and result emission.
`default_nettype none
module dfnms_core
    import dfnms_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cand_t       cand,
    input  wire cfg_t        cfg,
    output logic             done,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [87:0]      m_data,
    output logic             m_empty,
    output logic             m_overflow,
    output logic             m_final
);

    localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = $clog2(MAX_CANDIDATES + 1);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_SCAN      = 11'b00000000010,
        S_PICK_RD   = 11'b00000000100,
        S_PICK_AREA = 11'b00000001000,
        S_NMS_RD    = 11'b00000010000,
        S_NMS_A     = 11'b00000100000,
        S_NMS_B     = 11'b00001000000,
        S_NMS_C     = 11'b00010000000,
        S_EMIT_RD   = 11'b00100000000,
        S_EMIT_LD   = 11'b01000000000,
        S_EMIT_WAIT = 11'b10000000000
    } state_t;

    // Stores
    logic [63:0] box_mem  [MAX_CANDIDATES];
    logic [23:0] sc_mem   [MAX_CANDIDATES];
    logic [63:0] kbox_mem [OUT_CAP];
    logic [23:0] ksc_mem  [OUT_CAP];

    logic [63:0] box_rdata, kbox_rdata;
    logic [23:0] sc_rdata, ksc_rdata;
    logic [IW-1:0]  sc_raddr, box_raddr;
    logic [KIW-1:0] k_raddr;
    logic           st_we, k_we;

    state_t         st_reg, st_next;
    logic [CW-1:0]  cnt_reg, cnt_next, scan_reg, scan_next;
    logic           drop_reg, drop_next;
    logic           rdv_reg, rdv_next, found_reg, found_next, first_reg, first_next;
    logic [IW-1:0]  rdi_reg, rdi_next, best_i_reg, best_i_next, prev_i_reg, prev_i_next;
    logic [23:0]    best_sc_reg, best_sc_next;
    logic [15:0]    prev_s_reg, prev_s_next;
    logic [63:0]    cbox_reg, cbox_next;
    logic [31:0]    area_a_reg, area_a_next, inter_reg, inter_next;
    logic [31:0]    area_b_reg, area_b_next;
    logic           le_reg, le_next;
    logic [48:0]    prod_reg, prod_next;
    logic [KW-1:0]  kc_reg, kc_next, j_reg, j_next, e_reg, e_next, lim;
    logic           mv_reg, mv_next, me_reg, me_next, mf_reg, mf_next;
    logic [87:0]    md_reg, md_next;

    logic [15:0] s, ix1, iy1, ix2, iy2, iw, ih;
    logic [32:0] sum, uni;
    logic        elig, better;

    // Store writes and registered reads
    always_ff @(posedge aclk) begin
        if (st_we) begin
            box_mem[cnt_reg[IW-1:0]] <= cand.box;
            sc_mem[cnt_reg[IW-1:0]]  <= cand.sc;
        end
        if (k_we) begin
            kbox_mem[kc_reg[KIW-1:0]] <= cbox_reg;
            ksc_mem[kc_reg[KIW-1:0]]  <= best_sc_reg;
        end
        sc_rdata   <= sc_mem[sc_raddr];
        box_rdata  <= box_mem[box_raddr];
        kbox_rdata <= kbox_mem[k_raddr];
        ksc_rdata  <= ksc_mem[k_raddr];
    end

    always_comb begin
        lim = (cfg.keep_limit == '0 || cfg.keep_limit > KW'(OUT_CAP)) ? KW'(OUT_CAP)
                                                                      : cfg.keep_limit;
        // Scan compare: next in (score desc, index asc) after the previous pick
        s      = sc_rdata[15:0];
        elig   = first_reg || (s < prev_s_reg) || (s == prev_s_reg && rdi_reg > prev_i_reg);
        better = !found_reg || (s > best_sc_reg[15:0]);
        // Intersection against one kept box
        ix1 = (cbox_reg[15:0]  > kbox_rdata[15:0])  ? cbox_reg[15:0]  : kbox_rdata[15:0];
        iy1 = (cbox_reg[31:16] > kbox_rdata[31:16]) ? cbox_reg[31:16] : kbox_rdata[31:16];
        ix2 = (cbox_reg[47:32] < kbox_rdata[47:32]) ? cbox_reg[47:32] : kbox_rdata[47:32];
        iy2 = (cbox_reg[63:48] < kbox_rdata[63:48]) ? cbox_reg[63:48] : kbox_rdata[63:48];
        iw  = (ix2 > ix1) ? ix2 - ix1 : 16'd0;
        ih  = (iy2 > iy1) ? iy2 - iy1 : 16'd0;
        sum = {1'b0, area_a_reg} + {1'b0, area_b_reg};
        uni = sum - {1'b0, inter_reg};
    end

    // Sequencer
    always_comb begin
        st_next = st_reg;      cnt_next = cnt_reg;       scan_next = scan_reg;
        drop_next = drop_reg;  rdv_next = 1'b0;          found_next = found_reg;
        first_next = first_reg; rdi_next = rdi_reg;      best_i_next = best_i_reg;
        prev_i_next = prev_i_reg; best_sc_next = best_sc_reg; prev_s_next = prev_s_reg;
        cbox_next = cbox_reg;  area_a_next = area_a_reg; inter_next = inter_reg;
        area_b_next = area_b_reg; le_next = le_reg;      prod_next = prod_reg;
        kc_next = kc_reg;      j_next = j_reg;           e_next = e_reg;
        mv_next = mv_reg;      me_next = me_reg;         mf_next = mf_reg;
        md_next = md_reg;
        st_we = 1'b0; k_we = 1'b0; done = 1'b0;
        sc_raddr = scan_reg[IW-1:0];
        box_raddr = best_i_reg;
        k_raddr = j_reg[KIW-1:0];

        // Loading from the front end
        if (cand.valid && cand.keep) begin
            if (cnt_reg < CW'(MAX_CANDIDATES)) begin
                st_we    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end else begin
                drop_next = 1'b1;
            end
        end

        case (st_reg)
            S_IDLE: begin
                if (cand.valid && cand.last) begin
                    st_next = S_SCAN; scan_next = '0; found_next = 1'b0;
                    first_next = 1'b1; kc_next = '0;
                end
            end
            S_SCAN: begin
                if (scan_reg < cnt_reg) begin
                    rdv_next  = 1'b1;
                    rdi_next  = scan_reg[IW-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                if (rdv_reg && elig && better) begin
                    found_next = 1'b1; best_i_next = rdi_reg; best_sc_next = sc_rdata;
                end
                if (scan_reg >= cnt_reg && !rdv_reg) begin
                    if (found_reg) begin
                        st_next = S_PICK_RD;
                    end else begin
                        st_next = S_EMIT_RD; e_next = '0;
                    end
                end
            end
            S_PICK_RD: begin
                st_next = S_PICK_AREA;
            end
            S_PICK_AREA: begin
                cbox_next   = box_rdata;
                area_a_next = (box_rdata[47:32] - box_rdata[15:0]) *
                              (box_rdata[63:48] - box_rdata[31:16]);
                j_next  = '0;
                st_next = S_NMS_RD;
            end
            S_NMS_RD: begin
                if (j_reg == kc_reg) begin
                    // Survived every kept box
                    k_we = 1'b1;
                    kc_next = kc_reg + 1'b1;
                    prev_s_next = best_sc_reg[15:0]; prev_i_next = best_i_reg;
                    first_next = 1'b0;
                    if (kc_reg + 1'b1 == lim) begin
                        st_next = S_EMIT_RD; e_next = '0;
                    end else begin
                        st_next = S_SCAN; scan_next = '0; found_next = 1'b0;
                    end
                end else begin
                    st_next = S_NMS_A;
                end
            end
            S_NMS_A: begin
                inter_next  = iw * ih;
                area_b_next = (kbox_rdata[47:32] - kbox_rdata[15:0]) *
                              (kbox_rdata[63:48] - kbox_rdata[31:16]);
                st_next = S_NMS_B;
            end
            S_NMS_B: begin
                le_next   = (sum <= {1'b0, inter_reg});
                prod_next = cfg.iou_thr * uni;
                st_next   = S_NMS_C;
            end
            S_NMS_C: begin
                if (!le_reg && ({1'b0, inter_reg, 16'd0} > prod_reg)) begin
                    // Suppressed: move on to the next candidate
                    prev_s_next = best_sc_reg[15:0]; prev_i_next = best_i_reg;
                    first_next = 1'b0;
                    st_next = S_SCAN; scan_next = '0; found_next = 1'b0;
                end else begin
                    j_next  = j_reg + 1'b1;
                    st_next = S_NMS_RD;
                end
            end
            S_EMIT_RD: begin
                k_raddr = e_reg[KIW-1:0];
                if (kc_reg == '0) begin
                    mv_next = 1'b1; md_next = '0; me_next = 1'b1; mf_next = 1'b1;
                    st_next = S_EMIT_WAIT;
                end else begin
                    st_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                mv_next = 1'b1;
                md_next = {ksc_rdata, kbox_rdata};
                me_next = 1'b0;
                mf_next = (e_reg + 1'b1 == kc_reg);
                st_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    if (mf_reg) begin
                        cnt_next = '0; drop_next = 1'b0; kc_next = '0;
                        done = 1'b1;
                        st_next = S_IDLE;
                    end else begin
                        e_next  = e_reg + 1'b1;
                        st_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            rdv_reg  <= 1'b0;
            kc_reg   <= '0;
            mv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
            rdv_reg  <= rdv_next;
            kc_reg   <= kc_next;
            mv_reg   <= mv_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;     found_reg <= found_next;   first_reg <= first_next;
        rdi_reg <= rdi_next;       best_i_reg <= best_i_next; prev_i_reg <= prev_i_next;
        best_sc_reg <= best_sc_next; prev_s_reg <= prev_s_next; cbox_reg <= cbox_next;
        area_a_reg <= area_a_next; inter_reg <= inter_next;   area_b_reg <= area_b_next;
        le_reg <= le_next;         prod_reg <= prod_next;     j_reg <= j_next;
        e_reg <= e_next;           me_reg <= me_next;         mf_reg <= mf_next;
        md_reg <= md_next;
    end

    assign m_valid    = mv_reg;
    assign m_data     = md_reg;
    assign m_empty    = me_reg;
    assign m_overflow = drop_reg;
    assign m_final    = mf_reg;

    a_kept_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        kc_reg <= KW'(OUT_CAP))
        else $error("kept count above cap");
    a_store_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_CANDIDATES))
        else $error("stored count above capacity");
    a_valid_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> st_reg == S_EMIT_WAIT)
        else $error("result shown outside emission");
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && m_ready && mf_reg) |=> (st_reg == S_IDLE && cnt_reg == '0))
        else $error("frame not closed after final result");

endmodule
`default_nettype wire

// File: src/detection_filter_nms_topk.sv
// Candidates are taken one per cycle while input is not held off; each passes the front-end
// registers (numerators, products, mapped edges) before it reaches the store. After the last
// candidate, each ordering pass scans the store, a picked box is compared against each kept box
// in turn until one suppresses it, and each result waits on the output. Input is held off from
// the last candidate until the final result is taken.
// Reset: configuration returns to its defaults, counts and flags clear; stores are not cleared.
`default_nettype none
module detection_filter_nms_topk
    import dfnms_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // coord_a, coord_b, coord_c, coord_d, score, class_in
    input  wire logic [87:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // box_left, box_top, box_right, box_bottom, score_out, class_out
    output logic [87:0]      m_axis_tdata,
    // empty_res, overflow
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    cfg_t  cfg_reg;
    cand_t cand;
    logic  busy_reg, busy_next, done, acc;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.conf_thr       <= 16'd16384;
            cfg_reg.iou_thr        <= 16'd29491;
            cfg_reg.keep_limit     <= 7'd0;
            cfg_reg.box_format     <= FMT_CS_NOCLS;
            cfg_reg.fallback_class <= 8'd0;
            cfg_reg.inv_scale      <= 16'd4096;
            cfg_reg.pad_offset     <= 32'd0;
            cfg_reg.image_extent   <= 32'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CONF_THR:  cfg_reg.conf_thr       <= cfg_wdata[15:0];
                REG_IOU_THR:   cfg_reg.iou_thr        <= cfg_wdata[15:0];
                REG_KEEP_LIM:  cfg_reg.keep_limit     <= cfg_wdata[6:0];
                REG_BOX_FMT:   cfg_reg.box_format     <= (cfg_wdata[1:0] == 2'd3) ?
                                                         FMT_CS_CLS : cfg_wdata[1:0];
                REG_FALLBACK:  cfg_reg.fallback_class <= cfg_wdata[7:0];
                REG_INV_SCALE: cfg_reg.inv_scale      <= cfg_wdata[15:0];
                REG_PAD:       cfg_reg.pad_offset     <= cfg_wdata;
                REG_EXTENT:    cfg_reg.image_extent   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold input from the last item of a frame until its results are out
    assign acc = s_axis_tvalid && s_axis_tready;
    always_comb begin
        busy_next = busy_reg;
        if (acc && s_axis_tlast) begin
            busy_next = 1'b1;
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign s_axis_tready = !busy_reg;

    dfnms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (acc),
        .coord_a  (s_axis_tdata[15:0]),
        .coord_b  (s_axis_tdata[31:16]),
        .coord_c  (s_axis_tdata[47:32]),
        .coord_d  (s_axis_tdata[63:48]),
        .score    (s_axis_tdata[79:64]),
        .class_in (s_axis_tdata[87:80]),
        .last     (s_axis_tlast),
        .cfg      (cfg_reg),
        .cand     (cand)
    );

    dfnms_core #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cand       (cand),
        .cfg        (cfg_reg),
        .done       (done),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_empty    (m_axis_tuser[0]),
        .m_overflow (m_axis_tuser[1]),
        .m_final    (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the detection filter: table-driven directed frames, random frames, scoreboard.
`timescale 1ns / 1ps
module tb;
    import dfnms_pkg::*;

    localparam int CAP = 64;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [15:0] left, top, right, bottom, score;
        logic [7:0]  cls;
        logic        empty, ovf, fin;
    } box_res_t;

    typedef struct {
        logic [15:0] a, b, c, d, score;
        logic [7:0]  cls;
        logic        last;
        logic        has_exp;   // expected result typed in
        box_res_t    exp;
    } cand_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    detection_filter_nms_topk dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // Shadow configuration and frame state
    logic [15:0] sh_conf, sh_iou, sh_inv;
    logic [6:0]  sh_keep;
    logic [1:0]  sh_fmt;
    logic [7:0]  sh_fb;
    logic [31:0] sh_pad, sh_ext;
    logic [63:0] frame_boxes[$];
    logic [23:0] frame_sc[$];
    bit          frame_drop;

    box_res_t    pending_boxes[$];
    int          errors = 0;
    int          send_idle = 0, recv_idle = 0;
    bit          hold_recv = 0;
    int          quiet_cycles = 0;
    bit          all_sent = 0;

    function automatic logic [15:0] map_edge(longint n2, logic [15:0] pad, logic [15:0] extent);
        longint p, lim, r;
        p = (n2 - 2 * longint'(pad)) * longint'(sh_inv);
        lim = longint'(extent) * 16;
        if (lim > 65535) lim = 65535;
        if (p <= 0) return 16'd0;
        r = (p + 4096) >>> 13;
        return (r > lim) ? lim[15:0] : r[15:0];
    endfunction

    function automatic bit too_close(logic [63:0] x, logic [63:0] y);
        longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, x1, y1, x2, y2, w, h, inter, sum;
        ax1 = x[15:0]; ay1 = x[31:16]; ax2 = x[47:32]; ay2 = x[63:48];
        bx1 = y[15:0]; by1 = y[31:16]; bx2 = y[47:32]; by2 = y[63:48];
        x1 = ax1 > bx1 ? ax1 : bx1; y1 = ay1 > by1 ? ay1 : by1;
        x2 = ax2 < bx2 ? ax2 : bx2; y2 = ay2 < by2 ? ay2 : by2;
        w = x2 > x1 ? x2 - x1 : 0;
        h = y2 > y1 ? y2 - y1 : 0;
        inter = w * h;
        sum = (ax2 - ax1) * (ay2 - ay1) + (bx2 - bx1) * (by2 - by1);
        if (sum <= inter) return 0;
        return (inter * 65536) > (longint'(sh_iou) * (sum - inter));
    endfunction

    // Predict one accepted candidate; queue results into pending_boxes on the last one
    task automatic predict_candidate(cand_row_t c);
        longint a, b, cc, d;
        longint n[4];
        logic [15:0] l, t, r, bo;
        logic [7:0] cls;
        int order[$];
        int kept[$];
        int lim, j;
        bit sup;
        box_res_t o;
        a = longint'($signed(c.a)); b = longint'($signed(c.b));
        cc = longint'($signed(c.c)); d = longint'($signed(c.d));
        cls = (sh_fmt == FMT_CS_NOCLS) ? sh_fb : c.cls;
        if (c.score >= sh_conf) begin
            if (sh_fmt == FMT_CORNERS) begin
                n[0] = 2*a; n[1] = 2*b; n[2] = 2*cc; n[3] = 2*d;
            end else begin
                n[0] = 2*a - cc; n[1] = 2*b - d; n[2] = 2*a + cc; n[3] = 2*b + d;
            end
            l  = map_edge(n[0], sh_pad[15:0], sh_ext[15:0]);
            t  = map_edge(n[1], sh_pad[31:16], sh_ext[31:16]);
            r  = map_edge(n[2], sh_pad[15:0], sh_ext[15:0]);
            bo = map_edge(n[3], sh_pad[31:16], sh_ext[31:16]);
            if (r > l && bo > t) begin
                if (frame_boxes.size() >= CAP) frame_drop = 1;
                else begin
                    frame_boxes.insert(frame_boxes.size(), {bo, r, t, l});
                    frame_sc.insert(frame_sc.size(), {cls, c.score});
                end
            end
        end
        if (!c.last) return;
        // stable sort, descending score
        for (int i = 0; i < frame_boxes.size(); i++) begin
            j = 0;
            while (j < order.size() && frame_sc[order[j]][15:0] >= frame_sc[i][15:0]) j++;
            order.insert(j, i);
        end
        lim = (sh_keep != 0 && sh_keep < CAP) ? sh_keep : CAP;
        foreach (order[i]) begin
            if (kept.size() >= lim) break;
            sup = 0;
            foreach (kept[k]) if (!sup) sup = too_close(frame_boxes[order[i]], frame_boxes[kept[k]]);
            if (!sup) kept.insert(kept.size(), order[i]);
        end
        if (c.has_exp) begin
            // typed-in expectation for this frame
            pending_boxes.insert(pending_boxes.size(), c.exp);
        end else if (kept.size() == 0) begin
            o = '{default: '0};
            o.empty = 1; o.ovf = frame_drop; o.fin = 1;
            pending_boxes.insert(pending_boxes.size(), o);
        end else begin
            foreach (kept[i]) begin
                o.left = frame_boxes[kept[i]][15:0];
                o.top = frame_boxes[kept[i]][31:16];
                o.right = frame_boxes[kept[i]][47:32];
                o.bottom = frame_boxes[kept[i]][63:48];
                o.score = frame_sc[kept[i]][15:0];
                o.cls = frame_sc[kept[i]][23:16];
                o.empty = 0; o.ovf = frame_drop; o.fin = (i == kept.size() - 1);
                pending_boxes.insert(pending_boxes.size(), o);
            end
        end
        frame_boxes.delete(); frame_sc.delete(); frame_drop = 0;
    endtask

    // One write, then the enable drops again before the task returns
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            REG_CONF_THR:  sh_conf = val[15:0];
            REG_IOU_THR:   sh_iou = val[15:0];
            REG_KEEP_LIM:  sh_keep = val[6:0];
            REG_BOX_FMT:   sh_fmt = (val[1:0] == 2'd3) ? FMT_CS_CLS : val[1:0];
            REG_FALLBACK:  sh_fb = val[7:0];
            REG_INV_SCALE: sh_inv = val[15:0];
            REG_PAD:       sh_pad = val;
            REG_EXTENT:    sh_ext = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Offer one candidate, honoring the sender idle rate; valid stays up for the next one
    task automatic send_candidate(cand_row_t c);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {c.cls, c.score, c.d, c.c, c.b, c.a};
        s_axis_tlast <= c.last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_candidate(c);
    endtask

    // Drop valid, wait for the frame to drain, then let the block settle before a config write
    task automatic drain_frames();
        s_axis_tvalid <= 0;
        while (pending_boxes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic cand_row_t rand_cand(bit last);
        cand_row_t c;
        c.has_exp = 0; c.exp = '{default: '0};
        c.cls = 8'($urandom); c.last = last;
        c.score = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(65535, 12000));
        if ($urandom_range(9) == 0) begin
            c.a = 16'($urandom); c.b = 16'($urandom); c.c = 16'($urandom); c.d = 16'($urandom);
        end else if (sh_fmt == FMT_CORNERS) begin
            c.a = 16'($urandom_range(4000, 0)); c.b = 16'($urandom_range(4000, 0));
            c.c = 16'(c.a + $urandom_range(2500, 1)); c.d = 16'(c.b + $urandom_range(2500, 1));
        end else begin
            c.a = 16'($urandom_range(5000, 500)); c.b = 16'($urandom_range(5000, 500));
            c.c = 16'($urandom_range(2500, 16)); c.d = 16'($urandom_range(2500, 16));
        end
        return c;
    endfunction

    // Receiver: random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (hold_recv) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result checker
    always @(posedge aclk) begin
        box_res_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_boxes.size() == 0) begin
                $error("result with no expectation: %h", m_axis_tdata);
                errors++;
            end else begin
                e = pending_boxes.pop_front();
                if (m_axis_tdata[15:0] !== e.left) begin
                    $error("box_left exp %0d got %0d", e.left, m_axis_tdata[15:0]); errors++;
                end
                if (m_axis_tdata[31:16] !== e.top) begin
                    $error("box_top exp %0d got %0d", e.top, m_axis_tdata[31:16]); errors++;
                end
                if (m_axis_tdata[47:32] !== e.right) begin
                    $error("box_right exp %0d got %0d", e.right, m_axis_tdata[47:32]); errors++;
                end
                if (m_axis_tdata[63:48] !== e.bottom) begin
                    $error("box_bottom exp %0d got %0d", e.bottom, m_axis_tdata[63:48]);
                    errors++;
                end
                if (m_axis_tdata[79:64] !== e.score) begin
                    $error("score_out exp %0d got %0d", e.score, m_axis_tdata[79:64]); errors++;
                end
                if (m_axis_tdata[87:80] !== e.cls) begin
                    $error("class_out exp %0d got %0d", e.cls, m_axis_tdata[87:80]); errors++;
                end
                if (m_axis_tuser[0] !== e.empty) begin
                    $error("empty_res exp %0d got %0d", e.empty, m_axis_tuser[0]); errors++;
                end
                if (m_axis_tuser[1] !== e.ovf) begin
                    $error("overflow exp %0d got %0d", e.ovf, m_axis_tuser[1]); errors++;
                end
                if (m_axis_tlast !== e.fin) begin
                    $error("final_res exp %0d got %0d", e.fin, m_axis_tlast); errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn
            || (all_sent && pending_boxes.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL detection_filter_nms_topk");
            $finish;
        end
    end

    cand_row_t dir_rows[$];

    initial begin
        cand_row_t c;
        int nframe;
        box_res_t z;
        sh_conf = 16384; sh_iou = 29491; sh_keep = 0; sh_fmt = FMT_CS_NOCLS;
        sh_fb = 0; sh_inv = 4096; sh_pad = 0; sh_ext = 0;
        frame_drop = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // After reset extent is zero: every box clamps empty, single empty result
        z = '{default: '0}; z.empty = 1; z.fin = 1;
        dir_rows.insert(dir_rows.size(),
            '{16'h0100, 16'h0100, 16'h0080, 16'h0080, 16'hFFFF, 8'h00, 1, 1, z});
        foreach (dir_rows[i]) send_candidate(dir_rows[i]);
        drain_frames();

        // Directed frames under a working setup
        write_reg(REG_EXTENT, {16'd640, 16'd640});
        write_reg(REG_BOX_FMT, 32'(FMT_CORNERS));
        write_reg(REG_IOU_THR, 32'd32768);
        dir_rows.delete();
        // below threshold, extremes, overlapping tie pair, a separate tie, empty last box
        dir_rows.insert(dir_rows.size(),
            '{16'd100, 16'd100, 16'd200, 16'd200, 16'd16383, 8'd1, 0, 0, z});
        dir_rows.insert(dir_rows.size(),
            '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd65535, 8'd255, 0, 0, z});
        dir_rows.insert(dir_rows.size(),
            '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'd20000, 8'd7, 0, 0, z});
        dir_rows.insert(dir_rows.size(),
            '{16'd100, 16'd100, 16'd500, 16'd500, 16'd40000, 8'd3, 0, 0, z});
        dir_rows.insert(dir_rows.size(),
            '{16'd110, 16'd110, 16'd510, 16'd510, 16'd40000, 8'd4, 0, 0, z});
        dir_rows.insert(dir_rows.size(),
            '{16'd1000, 16'd1000, 16'd1200, 16'd1200, 16'd40000, 8'd5, 0, 0, z});
        dir_rows.insert(dir_rows.size(),
            '{16'd300, 16'd300, 16'd300, 16'd800, 16'd50000, 8'd6, 1, 0, z});
        foreach (dir_rows[i]) send_candidate(dir_rows[i]);
        drain_frames();

        // Centre-size with fallback class, pad, scale, keep limit, iou 0 and max
        write_reg(REG_BOX_FMT, 32'(FMT_CS_NOCLS));
        write_reg(REG_FALLBACK, 32'd255);
        write_reg(REG_PAD, {16'd160, 16'd80});
        write_reg(REG_INV_SCALE, 32'd6144);
        write_reg(REG_KEEP_LIM, 32'd2);
        write_reg(REG_IOU_THR, 32'd0);
        write_reg(REG_CONF_THR, 32'd0);
        for (int i = 0; i < 5; i++) send_candidate(rand_cand(i == 4));
        drain_frames();
        write_reg(REG_IOU_THR, 32'd65535);
        write_reg(REG_KEEP_LIM, 32'd127);
        write_reg(REG_INV_SCALE, 32'd65535);
        write_reg(REG_BOX_FMT, 32'd3);
        for (int i = 0; i < 5; i++) send_candidate(rand_cand(i == 4));
        drain_frames();
        write_reg(REG_INV_SCALE, 32'd0);
        for (int i = 0; i < 2; i++) send_candidate(rand_cand(i == 1));
        drain_frames();

        // Overflow frame: 70 boxes offered to a 64-entry store, receiver held off so the block stalls
        write_reg(REG_INV_SCALE, 32'd4096);
        write_reg(REG_PAD, 32'd0);
        write_reg(REG_EXTENT, 32'hFFFF_FFFF);
        write_reg(REG_KEEP_LIM, 32'd0);
        write_reg(REG_CONF_THR, 32'd0);
        write_reg(REG_IOU_THR, 32'd29491);
        hold_recv = 1;
        fork
            begin
                repeat (20000) @(posedge aclk);
                hold_recv = 0;
            end
        join_none
        for (int i = 0; i < 70; i++) begin
            c = rand_cand(0);
            c.a = 16'(40 + 60 * (i % 10)); c.b = 16'(40 + 60 * (i / 10));
            c.c = 16'd20; c.d = 16'd20; c.last = (i == 69);
            send_candidate(c);
        end
        // send a second frame while still held
        for (int i = 0; i < 3; i++) send_candidate(rand_cand(i == 2));
        drain_frames();

        // Random frames over three idle phases
        nframe = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 37 : (ph == 1) ? 53 : 0;
            recv_idle = (ph == 0) ? 53 : (ph == 1) ? 37 : 0;
            repeat (6) begin
                write_reg(REG_CONF_THR, $urandom_range(30000));
                write_reg(REG_IOU_THR, $urandom);
                write_reg(REG_KEEP_LIM, $urandom_range(8));
                write_reg(REG_BOX_FMT, $urandom_range(3));
                write_reg(REG_FALLBACK, $urandom);
                write_reg(REG_INV_SCALE, $urandom_range(8192, 2048));
                write_reg(REG_PAD, {16'($urandom_range(400)), 16'($urandom_range(400))});
                write_reg(REG_EXTENT, {16'($urandom_range(700, 100)),
                                       16'($urandom_range(700, 100))});
                nframe = $urandom_range(17, 1);
                for (int i = 0; i < nframe; i++) send_candidate(rand_cand(i == nframe - 1));
                drain_frames();
            end
        end

        all_sent = 1;
        while (pending_boxes.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("PASS detection_filter_nms_topk");
        else
            $display("FAIL detection_filter_nms_topk");
        $finish;
    end
endmodule
